@@ rtl/core/decimal_string_to_int32_defines.svh @@
// Assertion macros shared by the decimal string parser RTL.
`ifndef DECIMAL_STRING_TO_INT32_DEFINES_SVH
`define DECIMAL_STRING_TO_INT32_DEFINES_SVH

// Checked on clk_i, switched off while rst_ni is low.
`define DSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i, also while in reset.
`define DSI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/dsi_pkg.sv @@
// Types, codes and constants of the decimal string parser.
package dsi_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
  localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CLAMPED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  typedef enum logic [2:0] {
    TOK_SPACE,
    TOK_MINUS,
    TOK_PLUS,
    TOK_DIGIT,
    TOK_OTHER
  } tok_kind_e;

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/decimal_string_to_int32.sv @@
// Streaming decimal string to saturating signed 32-bit integer converter.
// Input channel: one character per transfer (char_code_i, last_char_i) on
//   in_valid_i / in_stall_o. last_char_i marks the final byte of a string,
//   which may itself be a zero byte.
// Output channel: one result per string (value_o, status_o) on
//   out_valid_o / out_stall_i. status: 0 normal, 1 clamped, 2 no digits.
// Leading spaces are skipped, one sign is taken, digits accumulate with
//   clamping at the 32-bit limits; the rest of the string is then ignored.
// Throughput: one character per cycle while in_stall_o is low; the
//   multiply-by-ten, add and limit compare in the back end are combinational.
// Result path: the last character is written into the queue, then the back
//   end pops it and loads the result into the output register; the pop
//   waits while a stalled result still holds the output register.
// A stalled result holds in the output register; characters of the next
//   string keep flowing until its last character reaches the back end, then
//   the queue fills (QueueDepth entries) and in_stall_o rises.
// Reset (asynchronous, rst_ni low) empties the queue, drops any pending
//   result and returns the parser to its space-skipping phase.
`include "decimal_string_to_int32_defines.svh"

module decimal_string_to_int32 #(
  parameter int unsigned QueueDepth = dsi_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);

  dsi_pkg::token_t  push_tok, pop_tok;
  dsi_pkg::q_stat_t q_stat;
  logic             push, pop;
  logic             res_empty, res_clamped, res_at_limit, pop_plain;

  dsi_front u_front (
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_stat_i    (q_stat),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .tok_o       (push_tok)
  );

  dsi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .pop_tok_o  (pop_tok),
    .stat_o     (q_stat)
  );

  dsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (pop_tok),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  assign res_empty    = out_valid_o && (status_o == dsi_pkg::STATUS_EMPTY);
  assign res_clamped  = out_valid_o && (status_o == dsi_pkg::STATUS_CLAMPED);
  assign res_at_limit = (value_o == dsi_pkg::VALUE_MAX) || (value_o == dsi_pkg::VALUE_MIN);
  assign pop_plain    = pop && !push_tok.last && !out_valid_o;

  `DSI_ASSERT(a_empty_zero, res_empty |-> value_o == '0, "no-digit result must be zero")
  `DSI_ASSERT(a_clamp_limit, res_clamped |-> res_at_limit, "clamped result not at a limit")
  `DSI_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue both full and empty")
  `DSI_ASSERT(a_stall_pending, in_stall_o |-> !q_stat.empty && !pop_plain, "stall, queue empty")
  `DSI_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o, "result pending right after reset")

endmodule

@@ rtl/core/dsi_front.sv @@
// Front end: classifies each incoming character into a token for the queue.
module dsi_front (
  input  logic                 in_valid_i,
  input  logic [7:0]           char_code_i,
  input  logic                 last_char_i,
  input  dsi_pkg::q_stat_t     q_stat_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output dsi_pkg::token_t      tok_o
);

  logic       is_digit;
  logic [7:0] digit_full;

  assign is_digit   = (char_code_i >= dsi_pkg::CHAR_ZERO) && (char_code_i <= dsi_pkg::CHAR_NINE);
  assign digit_full = char_code_i - dsi_pkg::CHAR_ZERO;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    tok_o.last  = last_char_i;
    tok_o.digit = digit_full[3:0];
    if (is_digit) begin
      tok_o.kind = dsi_pkg::TOK_DIGIT;
    end else begin
      unique case (char_code_i)
        dsi_pkg::CHAR_SPACE: tok_o.kind = dsi_pkg::TOK_SPACE;
        dsi_pkg::CHAR_MINUS: tok_o.kind = dsi_pkg::TOK_MINUS;
        dsi_pkg::CHAR_PLUS:  tok_o.kind = dsi_pkg::TOK_PLUS;
        default:             tok_o.kind = dsi_pkg::TOK_OTHER;
      endcase
    end
  end

endmodule

@@ rtl/core/dsi_queue.sv @@
// Short token queue between the classifier and the accumulator.
module dsi_queue #(
  parameter int unsigned Depth = dsi_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dsi_pkg::token_t   push_tok_i,
  input  logic              pop_i,
  output dsi_pkg::token_t   pop_tok_o,
  output dsi_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dsi_pkg::token_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

@@ rtl/core/dsi_back.sv @@
// Back end: applies tokens to the parse state and registers the result.
module dsi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dsi_pkg::token_t  tok_i,
  input  dsi_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [31:0]      value_o,
  output logic [1:0]       status_o
);

  dsi_pkg::phase_e phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic        clamped_q, clamped_d;
  logic        seen_q, seen_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q, value_d;
  logic [1:0]  status_q, status_d;

  logic        out_free;
  logic [35:0] mag_ext, next_mag, limit;

  assign out_free = !out_valid_q || !out_stall_i;
  // a last token needs room in the output register
  assign pop_o    = !q_stat_i.empty && (!tok_i.last || out_free);

  // magnitude * 10 + digit, never beyond 36 bits
  assign mag_ext  = {4'b0, mag_q};
  assign next_mag = (mag_ext << 3) + (mag_ext << 1) + {32'b0, tok_i.digit};
  assign limit    = neg_q ? dsi_pkg::LIMIT_NEG : dsi_pkg::LIMIT_POS;

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    clamped_d   = clamped_q;
    seen_d      = seen_q;
    value_d     = value_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (pop_o) begin
      unique case (phase_q)
        dsi_pkg::PH_SPACES, dsi_pkg::PH_SIGN, dsi_pkg::PH_DIGITS: begin
          if (tok_i.kind == dsi_pkg::TOK_DIGIT) begin
            seen_d = 1'b1;
            if (next_mag > limit) begin
              mag_d     = limit[31:0];
              clamped_d = 1'b1;
              phase_d   = dsi_pkg::PH_DONE;
            end else begin
              mag_d   = next_mag[31:0];
              phase_d = dsi_pkg::PH_DIGITS;
            end
          end else if (phase_q == dsi_pkg::PH_SPACES && tok_i.kind == dsi_pkg::TOK_SPACE) begin
            phase_d = dsi_pkg::PH_SPACES;
          end else if (phase_q == dsi_pkg::PH_SPACES && tok_i.kind == dsi_pkg::TOK_MINUS) begin
            neg_d   = 1'b1;
            phase_d = dsi_pkg::PH_SIGN;
          end else if (phase_q == dsi_pkg::PH_SPACES && tok_i.kind == dsi_pkg::TOK_PLUS) begin
            phase_d = dsi_pkg::PH_SIGN;
          end else begin
            phase_d = dsi_pkg::PH_DONE;
          end
        end
        dsi_pkg::PH_DONE: begin
          phase_d = dsi_pkg::PH_DONE;
        end
        default: begin
          phase_d = dsi_pkg::PH_DONE;
        end
      endcase

      if (tok_i.last) begin
        out_valid_d = 1'b1;
        if (!seen_d) begin
          value_d  = '0;
          status_d = dsi_pkg::STATUS_EMPTY;
        end else begin
          value_d  = neg_d ? (32'd0 - mag_d) : mag_d;
          status_d = clamped_d ? dsi_pkg::STATUS_CLAMPED : dsi_pkg::STATUS_OK;
        end
        phase_d   = dsi_pkg::PH_SPACES;
        neg_d     = 1'b0;
        mag_d     = '0;
        clamped_d = 1'b0;
        seen_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dsi_pkg::PH_SPACES;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      clamped_q   <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      clamped_q   <= clamped_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

@@ bench/decimal_string_to_int32_test.sv @@
// Self-checking testbench for the streaming decimal string to int32 converter.
`timescale 1ns / 100ps

module decimal_string_to_int32_test;

  localparam int unsigned MAX_GAP        = 19;
  localparam int unsigned RANDOM_CHARS   = 1640;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [7:0]  NUL_BYTE       = 8'h00;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } parse_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall_o;
  logic [7:0]  char_code;
  logic        last_char;
  logic        out_valid_o;
  logic        out_stall;
  logic [31:0] value_o;
  logic [1:0]  status_o;

  decimal_string_to_int32 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code),
    .last_char_i (last_char),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  // Parser state as the block should hold it
  dsi_pkg::phase_e parse_phase;
  logic            parse_negative;
  logic [31:0]     parse_magnitude;
  logic            parse_clamped;
  logic            parse_seen_digit;

  parse_result_t expected_results[$];

  bit idle_on = 1'b1;
  int errors;
  int strings_sent;
  int chars_sent;
  int results_checked;
  int clamped_results;
  int empty_results;
  int quiet_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic char_q_t chars(string s, bit nul_end);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    if (nul_end) q.push_back(NUL_BYTE);
    return q;
  endfunction

  task automatic clear_parse_state();
    parse_phase      = dsi_pkg::PH_SPACES;
    parse_negative   = 1'b0;
    parse_magnitude  = '0;
    parse_clamped    = 1'b0;
    parse_seen_digit = 1'b0;
  endtask

  // Advance the parser by one accepted character; queue a result on the last
  task automatic parse_char(logic [7:0] c, logic last);
    logic          is_digit;
    logic [35:0]   limit;
    logic [35:0]   next_mag;
    parse_result_t r;
    is_digit = (c >= dsi_pkg::CHAR_ZERO) && (c <= dsi_pkg::CHAR_NINE);
    if (parse_phase != dsi_pkg::PH_DONE) begin
      if (is_digit) begin
        limit    = parse_negative ? dsi_pkg::LIMIT_NEG : dsi_pkg::LIMIT_POS;
        next_mag = {4'b0, parse_magnitude} * 36'd10 + 36'(c - dsi_pkg::CHAR_ZERO);
        parse_seen_digit = 1'b1;
        if (next_mag > limit) begin
          parse_magnitude = limit[31:0];
          parse_clamped   = 1'b1;
          parse_phase     = dsi_pkg::PH_DONE;
        end else begin
          parse_magnitude = next_mag[31:0];
          parse_phase     = dsi_pkg::PH_DIGITS;
        end
      end else if (parse_phase == dsi_pkg::PH_SPACES && c == dsi_pkg::CHAR_MINUS) begin
        parse_negative = 1'b1;
        parse_phase    = dsi_pkg::PH_SIGN;
      end else if (parse_phase == dsi_pkg::PH_SPACES && c == dsi_pkg::CHAR_PLUS) begin
        parse_phase = dsi_pkg::PH_SIGN;
      end else if (!(parse_phase == dsi_pkg::PH_SPACES && c == dsi_pkg::CHAR_SPACE)) begin
        parse_phase = dsi_pkg::PH_DONE;
      end
    end
    if (last) begin
      if (!parse_seen_digit) begin
        r.value  = '0;
        r.status = dsi_pkg::STATUS_EMPTY;
      end else begin
        r.value  = parse_negative ? 32'd0 - parse_magnitude : parse_magnitude;
        r.status = parse_clamped ? dsi_pkg::STATUS_CLAMPED : dsi_pkg::STATUS_OK;
      end
      expected_results.push_back(r);
      clear_parse_state();
    end
  endtask

  // Called just after a falling edge; returns just after a falling edge with
  // valid still high, so back-to-back transfers keep it up.
  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= last;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    parse_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_chars(char_q_t text);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    strings_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_digit();
    return 8'(dsi_pkg::CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // Mostly well-formed numbers with random content, some noise and broken ones
  function automatic char_q_t random_text();
    char_q_t t;
    int      kind;
    int      n;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      repeat ($urandom_range(0, 3)) t.push_back(dsi_pkg::CHAR_SPACE);
      case ($urandom_range(0, 2))
        1:       t.push_back(dsi_pkg::CHAR_MINUS);
        2:       t.push_back(dsi_pkg::CHAR_PLUS);
        default: ;
      endcase
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
      if (n >= 10 && $urandom_range(0, 1) == 1) begin
        // close to the limits: exact limit, one past, and beyond
        t = {t, chars("214748364", 0)};
        n = n - 9;
      end
      repeat (n) t.push_back(random_digit());
      if ($urandom_range(0, 3) == 0) t.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) t.push_back(NUL_BYTE);
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 5))
          0:       t.push_back(dsi_pkg::CHAR_SPACE);
          1:       t.push_back(dsi_pkg::CHAR_MINUS);
          2:       t.push_back(dsi_pkg::CHAR_PLUS);
          3:       t.push_back(NUL_BYTE);
          default: t.push_back(random_digit());
        endcase
      end
    end
    return t;
  endfunction

  task automatic test_directed_cases();
    char_q_t q;
    send_chars(chars("", 1));
    send_chars(chars("0", 0));
    send_chars(chars("   -42", 0));
    send_chars(chars("+17", 1));
    send_chars(chars("-", 0));
    send_chars(chars("+-5", 0));
    send_chars(chars("-+5", 0));
    send_chars(chars("abc", 1));
    send_chars(chars("2147483647", 0));
    send_chars(chars("-2147483648", 1));
    send_chars(chars("2147483648", 0));
    send_chars(chars("-2147483649", 0));
    send_chars(chars("99999999999", 0));
    send_chars(chars("12-3", 0));
    send_chars(chars("4 5", 0));
    send_chars(chars("  ", 0));
    send_chars(chars("-007", 0));
    // zero byte inside the string ends the number, result only on the last
    q = chars("12", 1);
    q.push_back(dsi_pkg::CHAR_ZERO + 8'd3);
    q.push_back(dsi_pkg::CHAR_ZERO + 8'd4);
    send_chars(q);
    q = {8'hFF};
    send_chars(q);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (20) send_chars(random_text());
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (5) send_chars(random_text());
    wait_for_results();
    repeat (5) send_chars(random_text());
  endtask

  task automatic test_random_strings();
    int start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      if ($urandom_range(0, 24) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 59) == 0) wait_for_results();
      send_chars(random_text());
    end
    idle_on = 1'b1;
  endtask

  // Result side: random stall before each transfer, then check it
  initial begin : result_sink
    int            hold;
    parse_result_t r;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d",
                 $time, $signed(value_o), status_o);
        errors++;
      end else begin
        r = expected_results.pop_front();
        if (value_o !== r.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d",
                   $time, $signed(r.value), $signed(value_o));
          errors++;
        end
        if (status_o !== r.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, r.status, status_o);
          errors++;
        end
        results_checked++;
        if (r.status == dsi_pkg::STATUS_CLAMPED) clamped_results++;
        if (r.status == dsi_pkg::STATUS_EMPTY) empty_results++;
      end
    end
  end

  // Counts cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_results.size());
      $display("decimal_string_to_int32_test: errors");
      $finish;
    end
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    char_code = '0;
    last_char = 1'b0;
    clear_parse_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_back_to_back();
    test_drain_pause();
    test_random_strings();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d strings in %0d characters; %0d results checked,",
             strings_sent, chars_sent, results_checked);
    $display("%0d of them clamped at a limit and %0d with no digits.",
             clamped_results, empty_results);
    if (errors == 0) begin
      $display("decimal_string_to_int32_test: clean");
    end else begin
      $display("decimal_string_to_int32_test: errors");
    end
    $finish;
  end

endmodule
